>>> hw/rtl/lru_key_value_cache_core_macros.svh
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared property wrappers for the cache checker, sampled on clk and
// disabled while arst_n is low where noted
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define LRUKV_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define LRUKV_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lru key-value cache package
// request and response payload types and fixed constants
// ----------------------------------------------------------------------------
package lrukv_pkg;

	// width of the capacity register
	localparam int CAP_W = 5;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// read value returned on a get miss
	localparam logic signed [31:0] MISS_VALUE = -32'sd1;

	// read value returned for every set
	localparam logic signed [31:0] SET_VALUE = 32'sd0;

	// request kind
	typedef enum logic [0:0] {
		CMD_GET = 1'b0,
		CMD_SET = 1'b1
	} cmd_t;

	// request payload
	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	// response payload
	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
	} rsp_t;

endpackage

>>> hw/rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru key-value cache core
// fully associative key-value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// Usage:
// - requests enter on in_valid/in_ready with in_req (cmd, key, value);
//   responses leave on out_valid/out_ready with out_rsp (hit, read_value)
// - a get returns the stored value on a hit, -1 on a miss; a set writes the
//   value, returns 0 and flags whether the key was already present
// - capacity is written through cfg_we/cfg_wdata while no request is in
//   flight; 0 acts as 1 and values above ENTRIES act as ENTRIES
// - an accepted request is held in the request register; its response is
//   registered in the response register once that register is free
// - throughput: one request per cycle unless the output stalls; the whole
//   lookup, the priority pick of the matching slot and the one-step shift of
//   the recency chain are combinational between request and response registers
// - when out_ready is low the response register holds; one more request
//   is taken into the request register, then in_ready drops
// - reset empties the store (all slots invalid, count zero), sets capacity
//   to 16 and clears both pipeline valid flags; no clearing pass is needed
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
	parameter int ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  lrukv_pkg::req_t                in_req,
	output logic                           out_valid,
	input  logic                           out_ready,
	output lrukv_pkg::rsp_t                out_rsp,
	input  logic                           cfg_we,
	input  logic [lrukv_pkg::CAP_W-1:0]    cfg_wdata
);
	import lrukv_pkg::*;

	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	// pipeline and state registers
	logic                     vld_s1;
	req_t                     req_s1;
	logic                     out_vld_q;
	rsp_t                     rsp_q;
	logic [CAP_W-1:0]         capacity_q;
	logic [CW-1:0]            count_q;
	logic [ENTRIES-1:0]       valid_q;
	logic signed [31:0]       key_q [ENTRIES];
	logic signed [31:0]       val_q [ENTRIES];

	// combinational signals
	logic                     adv;
	logic                     fire;
	logic                     is_set;
	logic [ENTRIES-1:0]       match;
	logic                     found;
	logic [IW-1:0]            pos;
	logic [CMPW-1:0]          cap_ext;
	logic [CMPW-1:0]          eff_cap;
	logic                     full;
	logic [IW-1:0]            shift_pos;
	logic signed [31:0]       hit_value;
	logic signed [31:0]       front_val;
	logic                     do_update;
	logic                     grow;
	rsp_t                     rsp_d;

	// handshake
	assign adv       = !out_vld_q || out_ready;
	assign in_ready  = !vld_s1 || adv;
	assign fire      = vld_s1 && adv;
	assign out_valid = out_vld_q;
	assign out_rsp   = rsp_q;

	// parallel key compare over valid slots
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == req_s1.key);
		end
	end

	// first match, most recent slot wins
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				found = 1'b1;
				pos   = IW'(i);
			end
		end
	end

	// effective capacity and full flag
	always_comb begin
		cap_ext = CMPW'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_ext > CMPW'(ENTRIES)) begin
			eff_cap = CMPW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		full = CMPW'(count_q) >= eff_cap;
	end

	// slot to pull to the front and the value to place there
	always_comb begin
		is_set    = (req_s1.cmd == CMD_SET);
		hit_value = val_q[pos];
		if (found) begin
			shift_pos = pos;
		end else if (full) begin
			shift_pos = IW'(count_q - CW'(1));
		end else begin
			shift_pos = IW'(count_q);
		end
		front_val = is_set ? req_s1.value : hit_value;
		do_update = fire && (found || is_set);
		grow      = fire && is_set && !found && !full;
	end

	// response
	always_comb begin
		rsp_d.hit = found;
		if (is_set) begin
			rsp_d.read_value = SET_VALUE;
		end else if (found) begin
			rsp_d.read_value = hit_value;
		end else begin
			rsp_d.read_value = MISS_VALUE;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
			capacity_q <= CAP_RESET;
			count_q    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= vld_s1;
			end
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (grow) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	// front slot of the recency chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q[0] <= 1'b0;
		end else if (do_update) begin
			valid_q[0] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_update) begin
			key_q[0] <= req_s1.key;
			val_q[0] <= front_val;
		end
	end

	// remaining slots move back by one up to the chosen slot
	for (genvar g = 1; g < ENTRIES; g++) begin : g_slot
		logic shift_en;

		assign shift_en = do_update && (IW'(g) <= shift_pos);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[g] <= 1'b0;
			end else if (shift_en) begin
				valid_q[g] <= valid_q[g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (shift_en) begin
				key_q[g] <= key_q[g-1];
				val_q[g] <= val_q[g-1];
			end
		end
	end

endmodule

>>> hw/rtl/lrukv_checker.sv
// ----------------------------------------------------------------------------
// lru key-value cache checker
// port-level checks on the cache core, attached by bind
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_core_macros.svh"

module lrukv_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input lrukv_pkg::rsp_t out_rsp
);
	import lrukv_pkg::*;

	// no response shown while reset is applied
	`LRUKV_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "response valid during reset")

	// a stalled response holds
	`LRUKV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rsp), "stalled response changed")

	// back-pressure only when the response register is full and stalled
	`LRUKV_ASSERT(a_ready_cause, !in_ready |-> out_valid && !out_ready, "in_ready low without output stall")

	// an accepted request shows its response via the request and response registers when not stalled
	`LRUKV_ASSERT(a_latency, (in_valid && in_ready) ##1 out_ready |=> out_valid, "response missing after accepted request")

	// a miss reports either a set or the get miss value
	`LRUKV_ASSERT(a_miss_value, out_valid && !out_rsp.hit |-> (out_rsp.read_value == SET_VALUE) || (out_rsp.read_value == MISS_VALUE), "bad read value on miss")

endmodule

bind lru_key_value_cache_core lrukv_checker u_lrukv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_rsp   (out_rsp)
);

>>> bench/lru_cache_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru key-value cache response checker
// watches the request, response and capacity ports of the cache, keeps its
// own recency-ordered copy of the store, works out the response of every
// accepted request and compares each accepted response field by field
// ----------------------------------------------------------------------------
module lru_cache_checker #(
	parameter int ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  lrukv_pkg::req_t             in_req,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  lrukv_pkg::rsp_t             out_rsp,
	input  logic                        cfg_we,
	input  logic [lrukv_pkg::CAP_W-1:0] cfg_wdata,
	output int                          fail_count,
	output int                          pending_count
);
	import lrukv_pkg::*;

	// shadow store: slot 0 most recent, slot used_slots-1 least recent
	logic signed [31:0] slot_key [ENTRIES];
	logic signed [31:0] slot_value [ENTRIES];
	int unsigned        used_slots;
	logic [CAP_W-1:0]   capacity;
	int                 mismatches;

	// responses still owed by the cache, oldest first
	rsp_t awaited_rsp [$];

	assign fail_count = mismatches;

	// shift the more recent slots back by one and put the entry at the front
	function automatic void move_to_front(int unsigned pos, logic signed [31:0] k,
			logic signed [31:0] v);
		for (int unsigned i = pos; i > 0; i--) begin
			slot_key[i]   = slot_key[i-1];
			slot_value[i] = slot_value[i-1];
		end
		slot_key[0]   = k;
		slot_value[0] = v;
	endfunction

	// apply one request to the shadow store and return the response it gives
	function automatic rsp_t serve_request(req_t r);
		rsp_t        res;
		int unsigned pos;
		int unsigned limit;
		bit          found;
		found = 1'b0;
		pos   = 0;
		for (int unsigned i = 0; i < used_slots; i++) begin
			if (!found && slot_key[i] == r.key) begin
				found = 1'b1;
				pos   = i;
			end
		end
		// zero acts as one, anything above the slot count as the slot count
		if (capacity == 0)
			limit = 1;
		else if (capacity > ENTRIES)
			limit = ENTRIES;
		else
			limit = capacity;
		res.hit = found;
		if (r.cmd == CMD_GET) begin
			if (found) begin
				res.read_value = slot_value[pos];
				move_to_front(pos, r.key, slot_value[pos]);
			end else begin
				res.read_value = MISS_VALUE;
			end
		end else begin
			res.read_value = SET_VALUE;
			if (found) begin
				move_to_front(pos, r.key, r.value);
			end else begin
				// a new key at or over capacity drops the least recent entry
				if (used_slots >= limit && used_slots > 0)
					used_slots--;
				move_to_front(used_slots, r.key, r.value);
				used_slots++;
			end
		end
		return res;
	endfunction

	// watch the ports, predict on each request, compare on each response
	always @(posedge clk or negedge arst_n) begin : monitor
		rsp_t want;
		if (!arst_n) begin
			used_slots = 0;
			capacity   = CAP_RESET;
			mismatches = 0;
			awaited_rsp.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_rsp.size() == 0) begin
					mismatches++;
					$display("%0t: response with none outstanding, actual hit %0b value %h",
						$time, out_rsp.hit, out_rsp.read_value);
				end else begin
					want = awaited_rsp.pop_front();
					if (out_rsp.hit !== want.hit) begin
						mismatches++;
						$display("%0t: hit mismatch, expected %0b, actual %0b",
							$time, want.hit, out_rsp.hit);
					end
					if (out_rsp.read_value !== want.read_value) begin
						mismatches++;
						$display("%0t: read_value mismatch, expected %h, actual %h",
							$time, want.read_value, out_rsp.read_value);
					end
				end
			end
			if (in_valid && in_ready)
				awaited_rsp.push_back(serve_request(in_req));
			if (cfg_we)
				capacity = cfg_wdata;
			pending_count <= awaited_rsp.size();
		end
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru key-value cache testbench
// drives directed and random get/set requests through the cache across a
// range of capacity settings, with random gaps on both channels, two long
// response hold-offs and drains between settings; the checker beside the
// cache predicts and compares every response
// ----------------------------------------------------------------------------
module testbench;
	import lrukv_pkg::*;

	localparam int          ENTRIES     = 16;
	localparam int          STALL_LIMIT = 2000;
	localparam int          LONG_HOLD   = 60;
	localparam int          PHASE_ITEMS = 155;
	localparam int          PHASES      = 10;
	localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b1;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	req_t             in_req    = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	rsp_t             out_rsp;
	logic             cfg_we    = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic             no_idle   = 1'b0;
	int               fail_count;
	int               pending_count;

	// capacity settings of the random part, extremes and saturation included
	int phase_cap [PHASES] = '{16, 3, 31, 1, 0, 8, 17, 2, 12, 5};

	lru_key_value_cache_core #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rsp  (out_rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	lru_cache_checker #(
		.ENTRIES(ENTRIES)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_req       (in_req),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_rsp      (out_rsp),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// response side: random hold-off per response, two long hold-offs
	initial begin : receiver
		int stall;
		int taken;
		stall = 0;
		taken = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				taken++;
				if (taken == 400 || taken == 1200)
					stall = LONG_HOLD;
				else
					stall = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: too long without any handshake ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	// offer one request after a random gap and hold it until taken
	task automatic send_req(cmd_t c, logic [31:0] k, logic [31:0] v);
		req_t r;
		int   gap;
		r.cmd   = c;
		r.key   = k;
		r.value = v;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_req   <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering and wait until every response has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (3) @(posedge clk);
	endtask

	// capacity write, only while the cache is idle
	task automatic write_capacity(int cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap[CAP_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// key pool entry: mostly random, sometimes an extreme of the range
	function automatic logic [31:0] pool_key();
		logic [31:0] extremes [4];
		extremes = '{32'h0, ALL_ONES, KEY_MAX, KEY_MIN};
		if ($urandom_range(0, 7) == 0)
			return extremes[$urandom_range(0, 3)];
		return $urandom();
	endfunction

	// random requests over a small key pool so that hits and evictions occur
	task automatic random_phase(int cap, int count);
		logic [31:0] pool [32];
		logic [31:0] k;
		int          pool_n;
		pool_n = $urandom_range(1, (cap > ENTRIES ? ENTRIES : cap) + 6);
		for (int i = 0; i < pool_n; i++)
			pool[i] = pool_key();
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 8)
				k = pool[$urandom_range(0, pool_n - 1)];
			else
				k = $urandom();
			send_req(cmd_t'($urandom_range(0, 1)), k, $urandom());
		end
	endtask

	// stimulus and verdict
	initial begin
		// reset applied from the start so that the registers clear at once
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty store, extreme keys and values, overwrite, value of all ones
		write_capacity(16);
		send_req(CMD_GET, 32'h0, ALL_ONES);
		send_req(CMD_SET, KEY_MAX, KEY_MIN);
		send_req(CMD_SET, KEY_MIN, KEY_MAX);
		send_req(CMD_GET, KEY_MAX, 32'h0);
		send_req(CMD_GET, KEY_MIN, 32'h0);
		send_req(CMD_SET, KEY_MAX, ALL_ONES);
		send_req(CMD_GET, KEY_MAX, 32'h0);
		send_req(CMD_GET, ALL_ONES, 32'h0);
		send_req(CMD_SET, ALL_ONES, 32'h0);
		send_req(CMD_GET, ALL_ONES, KEY_MAX);

		// capacity of one, lowered below the number of entries held
		drain();
		write_capacity(1);
		send_req(CMD_SET, 32'd5, 32'd50);
		send_req(CMD_GET, KEY_MIN, 32'h0);
		send_req(CMD_SET, 32'd6, 32'd60);
		send_req(CMD_GET, 32'd5, 32'h0);

		// capacity zero acts as one
		drain();
		write_capacity(0);
		send_req(CMD_SET, 32'd7, 32'd70);
		send_req(CMD_GET, 32'd6, 32'h0);
		send_req(CMD_SET, 32'd8, 32'd80);

		// capacity above the slot count saturates
		drain();
		write_capacity(31);
		for (int i = 0; i < 4; i++)
			send_req(CMD_SET, 32'd100 + i, 32'd1000 + i);
		send_req(CMD_GET, 32'd7, 32'h0);
		send_req(CMD_GET, 32'h0, 32'h0);

		// random part, one capacity setting per phase, some phases at full rate
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_capacity(phase_cap[ph]);
			no_idle <= (ph == 2 || ph == 6);
			random_phase(phase_cap[ph], PHASE_ITEMS);
		end

		drain();
		if (fail_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
